>>> hw/rtl/framelet_line_demux_macros.svh
// assertion helpers used by the top-level rtl
`ifndef FRAMELET_LINE_DEMUX_MACROS_SVH
`define FRAMELET_LINE_DEMUX_MACROS_SVH

// same-cycle implication
`define FLD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framelet_line_demux: same-cycle check failed");

// next-cycle implication
`define FLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framelet_line_demux: next-cycle check failed");

`endif

>>> hw/rtl/fld_pkg.sv
`default_nettype none

package fld_pkg;

    localparam int DEF_MAX_LINE_SAMPLES = 4096;
    localparam int DEF_UV_WIDTH         = 128;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH = 4;

    localparam int MODE_W         = 2;
    localparam int COLOR_OFFSET_W = 8;
    localparam int LINE_SAMPLES_W = 13;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;

    localparam int RAW_W        = 8;
    localparam int DN_W         = 13;
    localparam int CUBE_W       = 2;
    localparam int OUT_LINE_W   = 20;
    localparam int BAND_W       = 3;
    localparam int OUT_SAMPLE_W = 12;
    localparam int SET_W        = 16;
    localparam int FRAME_W      = 3;
    localparam int LINE_IDX_W   = 4;
    localparam int HB_W         = 6;

    localparam logic [LINE_SAMPLES_W-1:0] LINE_SAMPLES_RST = 13'd1024;
    localparam logic [LINE_IDX_W-1:0]     UV_HEIGHT        = 4'd4;
    localparam logic [LINE_IDX_W-1:0]     VIS_HEIGHT       = 4'd14;
    localparam logic [FRAME_W-1:0]        UV_FRAMELETS     = 3'd2;
    localparam logic [FRAME_W-1:0]        FRAMES_COLOR     = 3'd7;
    localparam logic [FRAME_W-1:0]        FRAMES_VIS       = 3'd5;
    localparam logic [FRAME_W-1:0]        FRAMES_UV        = 3'd2;
    localparam logic [FRAME_W-1:0]        FRAMES_BW        = 3'd1;
    localparam logic [OUT_LINE_W-1:0]     OUT_LINE_MAX     = 20'hFFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_COLOR = 2'd0,
        MODE_VIS   = 2'd1,
        MODE_UV    = 2'd2,
        MODE_BW    = 2'd3
    } fld_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE         = 2'd0,
        CFG_COLOR_OFFSET = 2'd1,
        CFG_LINE_SAMPLES = 2'd2,
        CFG_DECOMPAND_EN = 2'd3
    } fld_cfg_idx_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } fld_op_t;

    localparam logic [CUBE_W-1:0] CUBE_UV_EVEN  = 2'd0;
    localparam logic [CUBE_W-1:0] CUBE_UV_ODD   = 2'd1;
    localparam logic [CUBE_W-1:0] CUBE_VIS_EVEN = 2'd2;
    localparam logic [CUBE_W-1:0] CUBE_VIS_ODD  = 2'd3;

    typedef struct packed {
        fld_mode_t                 mode;
        logic [COLOR_OFFSET_W-1:0] color_offset;
        logic [LINE_SAMPLES_W-1:0] line_samples;
        logic                      decompand_enable;
    } fld_cfg_t;

    typedef struct packed {
        logic                    is_load;
        logic [RAW_W-1:0]        raw_dn;
        logic [DN_W-1:0]         table_value;
        logic [CUBE_W-1:0]       dest_cube;
        logic                    is_uv;
        logic [SET_W-1:0]        set_count;
        logic [HB_W-1:0]         height_band;
        logic [LINE_IDX_W-1:0]   line_idx;
        logic [BAND_W-1:0]       out_band;
        logic [OUT_SAMPLE_W-1:0] out_sample;
        logic                    width_error;
    } fld_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/fld_ram.sv
`default_nettype none

module fld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fld_queue.sv
`default_nettype none

module fld_queue #(
    parameter int DEPTH = fld_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fld_pkg::fld_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output fld_pkg::fld_item_t head
);
    import fld_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    fld_item_t        mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fld_front.sv
`default_nettype none

module fld_front #(
    parameter int MAX_LINE_SAMPLES = fld_pkg::DEF_MAX_LINE_SAMPLES,
    parameter int UV_WIDTH         = fld_pkg::DEF_UV_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fld_pkg::fld_cfg_t             cfg,
    input  logic                          pos_clear,
    input  logic                          in_valid,
    input  logic                          operation,
    input  logic [fld_pkg::RAW_W-1:0]     raw_dn,
    input  logic [fld_pkg::DN_W-1:0]      table_value,
    input  logic                          q_full,
    output logic                          q_push,
    output fld_pkg::fld_item_t            q_item
);
    import fld_pkg::*;

    localparam int SCW     = $clog2(MAX_LINE_SAMPLES);
    localparam int LW      = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int UW      = $clog2(UV_WIDTH + 1);
    localparam int CW      = (LW > UW) ? LW : UW;
    localparam int UV_HALF = UV_WIDTH / 2;

    logic [SET_W-1:0]      set_cnt_reg, set_cnt_next;
    logic [FRAME_W-1:0]    frm_idx_reg, frm_idx_next;
    logic [LINE_IDX_W-1:0] line_idx_reg, line_idx_next;
    logic [SCW-1:0]        samp_cnt_reg, samp_cnt_next;

    logic [LW-1:0]         eff_len;
    logic [CW-1:0]         len_c, samp_c, samp_inc, uv_start, uv_end, osamp_c;
    logic                  is_uv, is_load, emit, werr, accept, even;
    logic [LINE_IDX_W-1:0] height;
    logic [FRAME_W-1:0]    band_idx, frm_count;
    logic [LINE_IDX_W:0]   line_inc;
    logic [FRAME_W:0]      frm_inc;
    logic [HB_W-1:0]       height_band;
    logic [CUBE_W-1:0]     cube;

    always_comb
    begin
        if (cfg.line_samples == '0)
        begin
            eff_len = LW'(1);
        end
        else if (32'(cfg.line_samples) > 32'(MAX_LINE_SAMPLES))
        begin
            eff_len = LW'(MAX_LINE_SAMPLES);
        end
        else
        begin
            eff_len = LW'(cfg.line_samples);
        end

        case (cfg.mode)
            MODE_COLOR: frm_count = FRAMES_COLOR;
            MODE_VIS:   frm_count = FRAMES_VIS;
            MODE_UV:    frm_count = FRAMES_UV;
            MODE_BW:    frm_count = FRAMES_BW;
            default:    frm_count = FRAMES_BW;
        endcase

        is_uv = (cfg.mode == MODE_UV)
             || ((cfg.mode == MODE_COLOR) && (frm_idx_reg < UV_FRAMELETS));
        height = is_uv ? UV_HEIGHT : VIS_HEIGHT;
        band_idx = ((cfg.mode == MODE_COLOR) && !is_uv) ? frm_idx_reg - UV_FRAMELETS
                                                        : frm_idx_reg;
        height_band = is_uv ? HB_W'({band_idx, 2'b00})
                            : HB_W'({3'b000, band_idx} * 6'd14);
        even = set_cnt_reg[0];
        if (is_uv)
        begin
            cube = even ? CUBE_UV_EVEN : CUBE_UV_ODD;
        end
        else
        begin
            cube = even ? CUBE_VIS_EVEN : CUBE_VIS_ODD;
        end

        // uv middle window
        len_c    = CW'(eff_len);
        samp_c   = CW'(samp_cnt_reg);
        uv_start = (len_c >> 1) - CW'(UV_HALF);
        uv_end   = (len_c >> 1) + CW'(UV_HALF);
        emit     = 1'b1;
        werr     = 1'b0;
        osamp_c  = samp_c;
        if (is_uv)
        begin
            if (len_c < CW'(UV_WIDTH))
            begin
                werr = 1'b1;
            end
            else if ((samp_c >= uv_start) && (samp_c < uv_end))
            begin
                osamp_c = samp_c - uv_start;
            end
            else
            begin
                emit = 1'b0;
            end
        end

        is_load = (fld_op_t'(operation) == OP_LOAD);
        accept  = in_valid && !q_full;
        q_push  = accept && (is_load || emit);

        q_item.is_load     = is_load;
        q_item.raw_dn      = raw_dn;
        q_item.table_value = table_value;
        q_item.dest_cube   = cube;
        q_item.is_uv       = is_uv;
        q_item.set_count   = set_cnt_reg;
        q_item.height_band = height_band;
        q_item.line_idx    = line_idx_reg;
        q_item.out_band    = band_idx + BAND_W'(1);
        q_item.out_sample  = OUT_SAMPLE_W'(osamp_c);
        q_item.width_error = werr;

        // position in the framelet set
        samp_inc      = samp_c + CW'(1);
        line_inc      = {1'b0, line_idx_reg} + (LINE_IDX_W + 1)'(1);
        frm_inc       = {1'b0, frm_idx_reg} + (FRAME_W + 1)'(1);
        set_cnt_next  = set_cnt_reg;
        frm_idx_next  = frm_idx_reg;
        line_idx_next = line_idx_reg;
        samp_cnt_next = samp_cnt_reg;
        if (pos_clear)
        begin
            set_cnt_next  = '0;
            frm_idx_next  = '0;
            line_idx_next = '0;
            samp_cnt_next = '0;
        end
        else if (accept && !is_load)
        begin
            if (samp_inc < len_c)
            begin
                samp_cnt_next = SCW'(samp_inc);
            end
            else
            begin
                samp_cnt_next = '0;
                if (line_inc < {1'b0, height})
                begin
                    line_idx_next = line_inc[LINE_IDX_W-1:0];
                end
                else
                begin
                    line_idx_next = '0;
                    if (frm_inc < {1'b0, frm_count})
                    begin
                        frm_idx_next = frm_inc[FRAME_W-1:0];
                    end
                    else
                    begin
                        frm_idx_next = '0;
                        set_cnt_next = set_cnt_reg + SET_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_cnt_reg  <= '0;
            frm_idx_reg  <= '0;
            line_idx_reg <= '0;
            samp_cnt_reg <= '0;
        end
        else
        begin
            set_cnt_reg  <= set_cnt_next;
            frm_idx_reg  <= frm_idx_next;
            line_idx_reg <= line_idx_next;
            samp_cnt_reg <= samp_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fld_back.sv
`default_nettype none

module fld_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fld_pkg::fld_cfg_t                  cfg,
    input  logic                               q_empty,
    input  fld_pkg::fld_item_t                 q_head,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fld_pkg::CUBE_W-1:0]         dest_cube,
    output logic [fld_pkg::OUT_LINE_W-1:0]     out_line,
    output logic [fld_pkg::BAND_W-1:0]         out_band,
    output logic [fld_pkg::OUT_SAMPLE_W-1:0]   out_sample,
    output logic [fld_pkg::DN_W-1:0]           pixel_dn,
    output logic                               width_error
);
    import fld_pkg::*;

    localparam int SUM_W = OUT_LINE_W + 1;

    logic                    b_valid_reg;
    logic [CUBE_W-1:0]       b_cube_reg;
    logic [OUT_LINE_W-1:0]   b_line_reg, b_line_next;
    logic [BAND_W-1:0]       b_band_reg;
    logic [OUT_SAMPLE_W-1:0] b_samp_reg;
    logic [RAW_W-1:0]        b_raw_reg;
    logic                    b_werr_reg;

    logic                    o_valid_reg;
    logic [CUBE_W-1:0]       o_cube_reg;
    logic [OUT_LINE_W-1:0]   o_line_reg;
    logic [BAND_W-1:0]       o_band_reg;
    logic [OUT_SAMPLE_W-1:0] o_samp_reg;
    logic [DN_W-1:0]         o_dn_reg, o_dn_next;
    logic                    o_werr_reg;

    logic                    out_ready, b_ready, pix_pop, ram_we;
    logic [DN_W-1:0]         ram_rdata;
    logic [SUM_W-1:0]        line_base, line_pad, line_sum;

    assign out_ready = !o_valid_reg || !out_stall;
    assign b_ready   = !b_valid_reg || out_ready;
    assign q_pop     = !q_empty && (q_head.is_load || b_ready);
    assign ram_we    = q_pop && q_head.is_load;
    assign pix_pop   = q_pop && !q_head.is_load;

    fld_ram #(
        .WIDTH (DN_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (TABLE_AW'(q_head.raw_dn)),
        .wdata (q_head.table_value),
        .re    (pix_pop),
        .raddr (TABLE_AW'(q_head.raw_dn)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        line_base = SUM_W'(q_head.set_count) * SUM_W'(q_head.is_uv ? UV_HEIGHT : VIS_HEIGHT);
        line_pad  = SUM_W'(cfg.color_offset) * SUM_W'(q_head.height_band);
        line_sum  = line_base + line_pad + SUM_W'(q_head.line_idx) + SUM_W'(1);
        b_line_next = (line_sum > SUM_W'(OUT_LINE_MAX)) ? OUT_LINE_MAX
                                                       : line_sum[OUT_LINE_W-1:0];
        o_dn_next = cfg.decompand_enable ? ram_rdata : DN_W'({b_raw_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= pix_pop;
            end
            if (out_ready)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_pop)
        begin
            b_cube_reg <= q_head.dest_cube;
            b_line_reg <= b_line_next;
            b_band_reg <= q_head.out_band;
            b_samp_reg <= q_head.out_sample;
            b_raw_reg  <= q_head.raw_dn;
            b_werr_reg <= q_head.width_error;
        end
        if (out_ready && b_valid_reg)
        begin
            o_cube_reg <= b_cube_reg;
            o_line_reg <= b_line_reg;
            o_band_reg <= b_band_reg;
            o_samp_reg <= b_samp_reg;
            o_dn_reg   <= o_dn_next;
            o_werr_reg <= b_werr_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign dest_cube   = o_cube_reg;
    assign out_line    = o_line_reg;
    assign out_band    = o_band_reg;
    assign out_sample  = o_samp_reg;
    assign pixel_dn    = o_dn_reg;
    assign width_error = o_werr_reg;

endmodule

`default_nettype wire

>>> hw/rtl/framelet_line_demux.sv
`default_nettype none
`include "framelet_line_demux_macros.svh"

// Routes 8-bit pushbroom samples to framelet cubes, decompanding them when enabled.
// One word is taken per clock while in_stall is low: the front classifies a
// sample the cycle it is accepted and writes it into a four-word queue, and the
// back pops one word per cycle unless the output stalls, reads the 256-entry
// decompand table (registered read) and hands the result to an output register.
// Table loads use one queue slot and give no word; UV samples outside the middle
// window give no word and never enter the queue. in_stall rises only when the
// queue is full. The table has no reset and must be loaded before decompanding
// is enabled; register writes are taken at any time and a write of mode or
// line_samples restarts the framelet position.

module framelet_line_demux #(
    parameter int MAX_LINE_SAMPLES = fld_pkg::DEF_MAX_LINE_SAMPLES,
    parameter int UV_WIDTH         = fld_pkg::DEF_UV_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fld_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fld_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [fld_pkg::RAW_W-1:0]          raw_dn,
    input  logic [fld_pkg::DN_W-1:0]           table_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fld_pkg::CUBE_W-1:0]         dest_cube,
    output logic [fld_pkg::OUT_LINE_W-1:0]     out_line,
    output logic [fld_pkg::BAND_W-1:0]         out_band,
    output logic [fld_pkg::OUT_SAMPLE_W-1:0]   out_sample,
    output logic [fld_pkg::DN_W-1:0]           pixel_dn,
    output logic                               width_error
);
    import fld_pkg::*;

    fld_mode_t                 mode_reg;
    logic [COLOR_OFFSET_W-1:0] color_offset_reg;
    logic [LINE_SAMPLES_W-1:0] line_samples_reg;
    logic                      decompand_en_reg;
    logic                      cfg_wr, pos_clear;
    fld_cfg_t                  cfg;
    logic                      q_push, q_pop, q_full, q_empty;
    fld_item_t                 q_item, q_head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign pos_clear = cfg_wr && ((fld_cfg_idx_t'(cfg_index) == CFG_MODE)
                               || (fld_cfg_idx_t'(cfg_index) == CFG_LINE_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_COLOR;
            color_offset_reg <= '0;
            line_samples_reg <= LINE_SAMPLES_RST;
            decompand_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (fld_cfg_idx_t'(cfg_index))
                CFG_MODE:         mode_reg         <= fld_mode_t'(cfg_data[MODE_W-1:0]);
                CFG_COLOR_OFFSET: color_offset_reg <= cfg_data[COLOR_OFFSET_W-1:0];
                CFG_LINE_SAMPLES: line_samples_reg <= cfg_data[LINE_SAMPLES_W-1:0];
                CFG_DECOMPAND_EN: decompand_en_reg <= cfg_data[0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode             = mode_reg;
        cfg.color_offset     = color_offset_reg;
        cfg.line_samples     = line_samples_reg;
        cfg.decompand_enable = decompand_en_reg;
    end

    assign in_stall = q_full;

    fld_front #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
        .UV_WIDTH         (UV_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pos_clear   (pos_clear),
        .in_valid    (in_valid),
        .operation   (operation),
        .raw_dn      (raw_dn),
        .table_value (table_value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    fld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    fld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dest_cube   (dest_cube),
        .out_line    (out_line),
        .out_band    (out_band),
        .out_sample  (out_sample),
        .pixel_dn    (pixel_dn),
        .width_error (width_error)
    );

    `FLD_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full)
    `FLD_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_empty)
    `FLD_ASSERT_NEXT(a_pop_frees_slot, q_full && q_pop && !q_push, !q_full)

endmodule

`default_nettype wire
